// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the packer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must never hold while out of reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

// The antecedent implies the consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/fwp_pkg.sv =====
// ----------------------------------------------------------------------------
// Five-bit word packer package
// Types, constants and the five-bit code shifter shared by the packer RTL.
// ----------------------------------------------------------------------------
package fwp_pkg;

    localparam int POS_BITS_DEF      = 32;
    localparam int ALPHABET_SIZE_DEF = 26;

    localparam logic [1:0] OP_LETTER     = 2'd0;
    localparam logic [1:0] OP_WORD_END   = 2'd1;
    localparam logic [1:0] OP_STREAM_END = 2'd2;

    localparam logic [4:0] CODE_WORD_END   = 5'd29;
    localparam logic [4:0] CODE_STREAM_END = 5'd30;
    localparam logic [2:0] BIT_INDEX_RESET = 3'd7;

    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_TABLE = 1'b1;

    typedef struct packed {
        logic [1:0] operation;
        logic [4:0] letter;
    } item_t;

    typedef struct packed {
        logic        out_kind;
        logic [7:0]  out_byte;
        logic [4:0]  table_letter;
        logic [31:0] table_position;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [7:0] acc;
        logic [2:0] idx;
        logic       done;
        logic [7:0] full_byte;
    } push_t;

    // Shifts a code in MSB first; at most one byte completes per code.
    function automatic push_t push_code(logic [7:0] acc, logic [2:0] idx, logic [4:0] code);
        push_t r;
        logic [7:0] a;
        logic [2:0] i;
        logic       done;
        logic [7:0] full_byte;
        a         = acc;
        i         = idx;
        done      = 1'b0;
        full_byte = '0;
        for (int k = 0; k < 5; k++)
        begin
            a[i] = a[i] | code[4-k];
            if (i == 3'd0)
            begin
                done      = 1'b1;
                full_byte = a;
                a         = '0;
                i         = BIT_INDEX_RESET;
            end
            else
            begin
                i = i - 3'd1;
            end
        end
        r.acc       = a;
        r.idx       = i;
        r.done      = done;
        r.full_byte = full_byte;
        return r;
    endfunction

endpackage

// ===== rtl/fwp_out_buf.sv =====
// ----------------------------------------------------------------------------
// Packer result buffer
// Output register with one skid entry, so results queue while the receiver stalls.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fwp_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  fwp_pkg::result_t push_data,
    output logic             full,
    output logic             valid,
    input  logic             stall,
    output fwp_pkg::result_t data
);
    import fwp_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_reg;
    result_t skid_reg;
    logic    pop;

    assign pop   = out_valid_reg && !stall;
    assign full  = skid_valid_reg;
    assign valid = out_valid_reg;
    assign data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (skid_valid_reg)
                begin
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= push;
                end
            end
            else if (push)
            begin
                if (out_valid_reg)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (push)
            begin
                out_reg <= push_data;
            end
        end
        else if (push)
        begin
            if (out_valid_reg)
            begin
                skid_reg <= push_data;
            end
            else
            begin
                out_reg <= push_data;
            end
        end
    end

    `ASSERT_IMPL(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg, "skid entry without output entry")
    `ASSERT_NEVER(a_push_when_full, clk, rst_n, push && skid_valid_reg, "result pushed into a full buffer")
    `ASSERT_NEXT(a_drain_empties, clk, rst_n, pop && !skid_valid_reg && !push, !out_valid_reg, "output stays valid after last word taken")

endmodule

// ===== rtl/five_bit_word_packer.sv =====
// ----------------------------------------------------------------------------
// Five-bit word packer
// Packs letter and word-end codes into bytes and reports first-letter positions.
// ----------------------------------------------------------------------------
// The item channel carries one symbol per word: a letter, an end of word or an
// end of stream. Each letter or end of word shifts a five-bit code into the
// byte accumulator, MSB first; a completed byte is pushed into the result
// buffer. Items are accepted back to back, one per cycle, while the two-entry
// result buffer has room.
// An end of stream adds its code, then sends one or two packed bytes and the
// first-letter table in letter order, one result per cycle while the buffer has
// room, with last set on the final table entry. The item channel stalls from that
// word until the last table entry has entered the result buffer.
// When the receiver stalls, results wait in the buffer and the item channel
// stalls once the buffer is full. Reset clears the accumulator, the symbol
// position and the table, and the block is ready in the first cycle after it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module five_bit_word_packer #(
    parameter int POS_BITS      = fwp_pkg::POS_BITS_DEF,
    parameter int ALPHABET_SIZE = fwp_pkg::ALPHABET_SIZE_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  fwp_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output fwp_pkg::result_t result
);
    import fwp_pkg::*;

    localparam int IDX_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_BYTE_A = 4'b0010,
        ST_BYTE_B = 4'b0100,
        ST_TABLE  = 4'b1000
    } drain_state_t;

    drain_state_t              state_reg;
    logic [7:0]                acc_reg;
    logic [2:0]                idx_reg;
    logic [POS_BITS-1:0]       pos_reg;
    logic                      at_start_reg;
    logic                      seen_reg;
    logic [4:0]                cur_reg;
    logic [ALPHABET_SIZE-1:0]  entry_valid_reg;
    logic [POS_BITS-1:0]       table_reg [ALPHABET_SIZE];
    logic [7:0]                byte_a_reg;
    logic [7:0]                flush_reg;
    logic                      flush_pending_reg;
    logic [IDX_W-1:0]          drain_idx_reg;

    logic                      in_acc;
    logic                      out_full;
    logic [4:0]                letter_c;
    logic [4:0]                code_sel;
    push_t                     pr;
    logic                      first_hit;
    logic                      table_last;
    logic [POS_BITS-1:0]       entry_value;
    logic [POS_BITS+31:0]      entry_ext;
    logic                      push;
    result_t                   push_data;

    assign item_stall = (state_reg != ST_IDLE) || out_full;
    assign in_acc     = item_valid && !item_stall;
    assign letter_c   = (item.letter >= 5'(ALPHABET_SIZE)) ? 5'(ALPHABET_SIZE - 1) : item.letter;
    assign first_hit  = at_start_reg && (!seen_reg || cur_reg != letter_c);
    assign table_last = drain_idx_reg == IDX_W'(ALPHABET_SIZE - 1);
    assign entry_value = entry_valid_reg[drain_idx_reg] ? table_reg[drain_idx_reg] : '0;
    assign entry_ext  = {32'd0, entry_value};

    always_comb
    begin
        case (item.operation)
            OP_LETTER:   code_sel = letter_c;
            OP_WORD_END: code_sel = CODE_WORD_END;
            default:     code_sel = CODE_STREAM_END;
        endcase
    end

    assign pr = push_code(acc_reg, idx_reg, code_sel);

    always_comb
    begin
        push      = 1'b0;
        push_data = '0;
        case (state_reg)
            ST_IDLE:
            begin
                push = in_acc && pr.done
                    && (item.operation == OP_LETTER || item.operation == OP_WORD_END);
                push_data.out_kind = KIND_BYTE;
                push_data.out_byte = pr.full_byte;
            end
            ST_BYTE_A:
            begin
                push = !out_full;
                push_data.out_kind = KIND_BYTE;
                push_data.out_byte = byte_a_reg;
            end
            ST_BYTE_B:
            begin
                push = !out_full;
                push_data.out_kind = KIND_BYTE;
                push_data.out_byte = flush_reg;
            end
            ST_TABLE:
            begin
                push = !out_full;
                push_data.out_kind       = KIND_TABLE;
                push_data.table_letter   = 5'(drain_idx_reg);
                push_data.table_position = entry_ext[31:0];
                push_data.last           = table_last;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            acc_reg           <= '0;
            idx_reg           <= BIT_INDEX_RESET;
            pos_reg           <= '0;
            at_start_reg      <= 1'b1;
            seen_reg          <= 1'b0;
            cur_reg           <= '0;
            entry_valid_reg   <= '0;
            flush_pending_reg <= 1'b0;
            drain_idx_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        case (item.operation)
                            OP_LETTER:
                            begin
                                if (first_hit)
                                begin
                                    cur_reg  <= letter_c;
                                    seen_reg <= 1'b1;
                                    entry_valid_reg[letter_c[IDX_W-1:0]] <= 1'b1;
                                end
                                at_start_reg <= 1'b0;
                                acc_reg      <= pr.acc;
                                idx_reg      <= pr.idx;
                                pos_reg      <= pos_reg + POS_BITS'(1);
                            end
                            OP_WORD_END:
                            begin
                                at_start_reg <= 1'b1;
                                acc_reg      <= pr.acc;
                                idx_reg      <= pr.idx;
                                pos_reg      <= pos_reg + POS_BITS'(1);
                            end
                            OP_STREAM_END:
                            begin
                                flush_pending_reg <= pr.idx != BIT_INDEX_RESET;
                                if (pr.done)
                                begin
                                    state_reg <= ST_BYTE_A;
                                end
                                else if (pr.idx != BIT_INDEX_RESET)
                                begin
                                    state_reg <= ST_BYTE_B;
                                end
                                else
                                begin
                                    state_reg <= ST_TABLE;
                                end
                                acc_reg      <= '0;
                                idx_reg      <= BIT_INDEX_RESET;
                                pos_reg      <= '0;
                                at_start_reg <= 1'b1;
                                seen_reg     <= 1'b0;
                                cur_reg      <= '0;
                            end
                            default:
                            begin
                                acc_reg <= acc_reg;
                            end
                        endcase
                    end
                end
                ST_BYTE_A:
                begin
                    if (!out_full)
                    begin
                        state_reg <= flush_pending_reg ? ST_BYTE_B : ST_TABLE;
                    end
                end
                ST_BYTE_B:
                begin
                    if (!out_full)
                    begin
                        state_reg <= ST_TABLE;
                    end
                end
                ST_TABLE:
                begin
                    if (!out_full)
                    begin
                        if (table_last)
                        begin
                            drain_idx_reg   <= '0;
                            entry_valid_reg <= '0;
                            state_reg       <= ST_IDLE;
                        end
                        else
                        begin
                            drain_idx_reg <= drain_idx_reg + IDX_W'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && item.operation == OP_LETTER && first_hit)
        begin
            table_reg[letter_c[IDX_W-1:0]] <= pos_reg;
        end
        if (in_acc && item.operation == OP_STREAM_END)
        begin
            byte_a_reg <= pr.full_byte;
            flush_reg  <= pr.acc;
        end
    end

    fwp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (out_full),
        .valid     (result_valid),
        .stall     (result_stall),
        .data      (result)
    );

    `ASSERT_IMPL(a_empty_acc, clk, rst_n,
        idx_reg == BIT_INDEX_RESET, acc_reg == 8'd0,
        "accumulator holds bits at a byte boundary")
    `ASSERT_NEXT(a_stream_end_drains, clk, rst_n,
        in_acc && item.operation == OP_STREAM_END, state_reg != ST_IDLE,
        "stream end did not start the table drain")
    `ASSERT_IMPL(a_last_from_table, clk, rst_n,
        push && push_data.last, state_reg == ST_TABLE && table_last,
        "last flag outside the final table entry")

endmodule

// ===== test/tb_five_bit_word_packer.sv =====
// ----------------------------------------------------------------------------
// Five-bit word packer testbench
// Sends words through a randomly idling item channel and a randomly stalling
// result channel. A model of the packer, kept in this module, predicts every
// packed byte and every first-letter table entry. Each accepted result is
// checked field by field against the oldest prediction. A short run of
// directed words covers the extremes, the special cases and the three flush
// lengths at stream end. Random streams of sorted words, with noise and
// broken sequences, follow the directed words.
// ----------------------------------------------------------------------------
module tb_five_bit_word_packer;

    timeunit 1ns;
    timeprecision 1ps;

    import fwp_pkg::*;

    localparam int         ALPHABET     = ALPHABET_SIZE_DEF;
    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         RANDOM_WORDS = 140;
    localparam int         HOLD_CYCLES  = 80;
    localparam int         SETTLE       = 40;
    localparam int         CYCLE_LIMIT  = 200000;

    typedef struct {
        logic [1:0] op;
        logic [4:0] letter;
        bit         typed;
        logic [7:0] first_byte;
    } directed_row_t;

    // Stream sizes give one, two and zero flush bytes at stream end.
    directed_row_t directed_rows [20] = '{
        '{OP_STREAM_END, 5'd0,  1'b1, 8'hF0},
        '{OP_LETTER,     5'd25, 1'b0, 8'h00},
        '{OP_LETTER,     5'd31, 1'b0, 8'h00},
        '{OP_WORD_END,   5'd0,  1'b0, 8'h00},
        '{OP_WORD_END,   5'd0,  1'b0, 8'h00},
        '{OP_UNUSED,     5'd31, 1'b0, 8'h00},
        '{OP_LETTER,     5'd0,  1'b0, 8'h00},
        '{OP_WORD_END,   5'd0,  1'b0, 8'h00},
        '{OP_STREAM_END, 5'd0,  1'b0, 8'h00},
        '{OP_LETTER,     5'd1,  1'b0, 8'h00},
        '{OP_WORD_END,   5'd0,  1'b0, 8'h00},
        '{OP_LETTER,     5'd1,  1'b0, 8'h00},
        '{OP_LETTER,     5'd2,  1'b0, 8'h00},
        '{OP_WORD_END,   5'd0,  1'b0, 8'h00},
        '{OP_UNUSED,     5'd0,  1'b0, 8'h00},
        '{OP_LETTER,     5'd26, 1'b0, 8'h00},
        '{OP_WORD_END,   5'd0,  1'b0, 8'h00},
        '{OP_STREAM_END, 5'd0,  1'b0, 8'h00},
        '{OP_LETTER,     5'd25, 1'b0, 8'h00},
        '{OP_STREAM_END, 5'd0,  1'b1, 8'hCF}
    };

    logic    clk = 1'b0;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    result_t    expected_packer_out [$];
    logic [7:0] model_acc;
    logic [2:0] model_free_bit;
    logic [31:0] model_position;
    logic       model_word_start;
    logic       model_have_first;
    logic [4:0] model_first_letter;
    logic [31:0] model_first_pos [ALPHABET];

    int  mismatches = 0;
    int  cycle_count = 0;
    int  words_sent = 0;
    int  burst_left = 0;
    bit  hold_request = 1'b0;

    five_bit_word_packer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("five_bit_word_packer verification failed");
            $finish;
        end
    end

    task automatic clear_packer_model();
        model_acc          = '0;
        model_free_bit     = BIT_INDEX_RESET;
        model_position     = '0;
        model_word_start   = 1'b1;
        model_have_first   = 1'b0;
        model_first_letter = '0;
        for (int i = 0; i < ALPHABET; i++)
        begin
            model_first_pos[i] = '0;
        end
    endtask

    task automatic expect_packed_byte(input logic [7:0] value);
        result_t r;
        r          = '0;
        r.out_kind = KIND_BYTE;
        r.out_byte = value;
        expected_packer_out.push_back(r);
    endtask

    task automatic shift_in_code(input logic [4:0] code);
        for (int b = 4; b >= 0; b--)
        begin
            model_acc[model_free_bit] = code[b];
            if (model_free_bit == 3'd0)
            begin
                expect_packed_byte(model_acc);
                model_acc      = '0;
                model_free_bit = BIT_INDEX_RESET;
            end
            else
            begin
                model_free_bit = model_free_bit - 3'd1;
            end
        end
    endtask

    task automatic predict_packer(input item_t w);
        logic [4:0] sym;
        result_t    r;
        case (w.operation)
            OP_LETTER:
            begin
                sym = (w.letter >= ALPHABET) ? 5'(ALPHABET - 1) : w.letter;
                if (model_word_start)
                begin
                    if (!model_have_first || model_first_letter != sym)
                    begin
                        model_first_letter   = sym;
                        model_have_first     = 1'b1;
                        model_first_pos[sym] = model_position;
                    end
                    model_word_start = 1'b0;
                end
                shift_in_code(sym);
                model_position = model_position + 32'd1;
            end
            OP_WORD_END:
            begin
                shift_in_code(CODE_WORD_END);
                model_position   = model_position + 32'd1;
                model_word_start = 1'b1;
            end
            OP_STREAM_END:
            begin
                shift_in_code(CODE_STREAM_END);
                if (model_free_bit != BIT_INDEX_RESET)
                begin
                    expect_packed_byte(model_acc);
                end
                for (int i = 0; i < ALPHABET; i++)
                begin
                    r                = '0;
                    r.out_kind       = KIND_TABLE;
                    r.table_letter   = 5'(i);
                    r.table_position = model_first_pos[i];
                    r.last           = (i == ALPHABET - 1);
                    expected_packer_out.push_back(r);
                end
                clear_packer_model();
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n === 1'b1 && result_valid === 1'b1 && result_stall === 1'b0)
        begin
            if (expected_packer_out.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %h", $time, result);
            end
            else
            begin
                want = expected_packer_out.pop_front();
                compare_field("out_kind", 32'(want.out_kind), 32'(result.out_kind));
                compare_field("out_byte", 32'(want.out_byte), 32'(result.out_byte));
                compare_field("table_letter", 32'(want.table_letter),
                              32'(result.table_letter));
                compare_field("table_position", want.table_position, result.table_position);
                compare_field("last", 32'(want.last), 32'(result.last));
            end
        end
    end

    // The receiver switches between free running, light and heavy stalling,
    // with one long hold-off that lets the block fill up.
    initial
    begin : receiver
        int mode;
        int mode_left;
        int hold_left;
        bit hold_done;
        mode         = 0;
        mode_left    = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(10, 60);
                end
                mode_left--;
                case (mode)
                    0:       result_stall <= 1'b0;
                    1:       result_stall <= ($urandom_range(0, 3) == 0);
                    default: result_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic offer_word(input logic [1:0] op, input logic [4:0] letter,
                              input bit typed, input logic [7:0] typed_byte);
        item_t w;
        int    first_new;
        w.operation = op;
        w.letter    = letter;
        pace_sender();
        item       <= w;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall !== 1'b0)
        begin
            @(posedge clk);
        end
        first_new = expected_packer_out.size();
        predict_packer(w);
        if (typed && expected_packer_out.size() > first_new)
        begin
            expected_packer_out[first_new].out_byte = typed_byte;
        end
        if (op != OP_UNUSED)
        begin
            words_sent++;
        end
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        item_valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (expected_packer_out.size() != 0);
    endtask

    initial
    begin : sender
        int stream_no;
        int word_count;
        int word_len;
        int lead;
        int target;
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        clear_packer_model();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            offer_word(directed_rows[i].op, directed_rows[i].letter,
                       directed_rows[i].typed, directed_rows[i].first_byte);
        end
        wait_for_results();

        target    = words_sent + RANDOM_WORDS;
        stream_no = 0;
        while (words_sent < target)
        begin
            stream_no++;
            if (stream_no == 2)
            begin
                hold_request = 1'b1;
            end
            if (stream_no == 5)
            begin
                wait_for_results();
            end
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(3, 12))
                begin
                    offer_word(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                               1'b0, 8'h00);
                end
            end
            else
            begin
                word_count = $urandom_range(1, 8);
                lead       = $urandom_range(0, 6);
                for (int wi = 0; wi < word_count; wi++)
                begin
                    if (wi > 0)
                    begin
                        lead = lead + $urandom_range(0, 3);
                        if (lead > 31)
                        begin
                            lead = 31;
                        end
                    end
                    word_len = $urandom_range(0, 6);
                    for (int li = 0; li < word_len; li++)
                    begin
                        if ($urandom_range(0, 11) == 0)
                        begin
                            offer_word(OP_UNUSED, 5'($urandom_range(0, 31)), 1'b0, 8'h00);
                        end
                        if (li == 0)
                        begin
                            offer_word(OP_LETTER, 5'(lead), 1'b0, 8'h00);
                        end
                        else if ($urandom_range(0, 15) == 0)
                        begin
                            offer_word(OP_LETTER, 5'($urandom_range(26, 31)), 1'b0, 8'h00);
                        end
                        else
                        begin
                            offer_word(OP_LETTER, 5'($urandom_range(0, 25)), 1'b0, 8'h00);
                        end
                    end
                    if ($urandom_range(0, 19) != 0)
                    begin
                        offer_word(OP_WORD_END, 5'($urandom_range(0, 31)), 1'b0, 8'h00);
                    end
                end
                offer_word(OP_STREAM_END, 5'($urandom_range(0, 31)), 1'b0, 8'h00);
            end
        end

        wait_for_results();
        repeat (SETTLE) @(negedge clk);
        if (mismatches == 0)
        begin
            $display("five_bit_word_packer verification clean");
        end
        else
        begin
            $display("five_bit_word_packer verification failed");
        end
        $finish;
    end

endmodule
